FILE: hdl/mrq_pkg.sv
package mrq_pkg;

    // Default sizing of the queue.
    localparam int SLOTS_DEF     = 16;
    localparam int MAX_BYTES_DEF = 64;

    // Depth of the command queue between front and back end.
    localparam int CMDQ_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef logic [6:0] t_size;
    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_qcnt;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAPACITY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_BYTES = 1'd1;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command class decided by the front end.
    typedef enum logic [1:0] {
        K_SEND  = 2'd0,
        K_READ  = 2'd1,
        K_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_op   operation;
        t_byte in_byte;
        logic  in_byte_valid;
        logic  in_last;
        t_size read_limit;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_byte   out_byte;
        logic    out_byte_valid;
        t_size   stored_size;
        t_qcnt   queued_count;
        logic    out_last;
    } t_out_item;

    typedef struct packed {
        t_kind kind;
        logic  pop;
        t_byte data;
        logic  data_valid;
        logic  last;
        t_size limit;
    } t_cmd;

endpackage

FILE: hdl/mrq_ram.sv
module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/mrq_front.sv
module mrq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mrq_pkg::t_in_item i_in,
    output logic              o_cmd_valid,
    output mrq_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    localparam int DEPTH = mrq_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrq_pkg::t_cmd    r_q [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_cnt;
    logic             push;
    mrq_pkg::t_cmd    cls;

    // Classify the incoming item into a command for the back end.
    always_comb begin
        cls            = '0;
        cls.data       = i_in.in_byte;
        cls.data_valid = i_in.in_byte_valid;
        cls.last       = i_in.in_last;
        cls.limit      = i_in.read_limit;
        cls.pop        = (i_in.operation == mrq_pkg::OP_POP);
        unique case (i_in.operation)
            mrq_pkg::OP_SEND:  cls.kind = mrq_pkg::K_SEND;
            mrq_pkg::OP_PEEK,
            mrq_pkg::OP_POP:   cls.kind = mrq_pkg::K_READ;
            mrq_pkg::OP_CLEAR: cls.kind = mrq_pkg::K_CLEAR;
            default:           cls.kind = mrq_pkg::K_CLEAR;
        endcase
    end

    assign o_in_stall  = (r_cnt == CNT_W'(DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Pointer and fill count updates of the command queue.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

FILE: hdl/mrq_back.sv
module mrq_back #(
    parameter int SLOTS     = mrq_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = mrq_pkg::MAX_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(SLOTS + 1)-1:0] i_cap,
    input  mrq_pkg::t_size               i_max,
    input  logic                         i_cmd_valid,
    input  mrq_pkg::t_cmd                i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_out_valid,
    output mrq_pkg::t_out_item           o_out,
    input  logic                         i_out_stall
);

    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OFF_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int PAY_DEPTH = SLOTS * (2 ** OFF_W);
    localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIZE,
        S_STREAM
    } t_state;

    t_state r_state, n_state;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_held, n_held;
    mrq_pkg::t_size     r_off, n_off;
    logic               r_open, n_open;
    logic               r_rej, n_rej;
    mrq_pkg::t_size     r_limit, n_limit;
    logic               r_pop, n_pop;
    mrq_pkg::t_size     r_size, n_size;
    mrq_pkg::t_size     r_n, n_n;
    mrq_pkg::t_size     r_idx, n_idx;
    logic               r_pend_valid, n_pend_valid;
    mrq_pkg::t_out_item r_pend, n_pend;

    // Result queue that parts the back end from the output port.
    mrq_pkg::t_out_item r_q [2];
    logic               r_qwp;
    logic               r_qrp;
    logic [1:0]         r_qcnt;
    mrq_pkg::t_out_item push_item;
    logic               q_pop;

    // Memory ports.
    logic               pay_wr_en;
    logic [PAY_AW-1:0]  pay_wr_addr;
    logic               pay_rd_en;
    logic [PAY_AW-1:0]  pay_rd_addr;
    mrq_pkg::t_byte     pay_rd_data;
    logic               size_wr_en;
    mrq_pkg::t_size     size_wr_data;
    logic               size_rd_en;
    mrq_pkg::t_size     size_rd_data;

    // Send bookkeeping for the current item.
    mrq_pkg::t_size     s_off;
    logic               s_rej;
    logic               s_wr;
    mrq_pkg::t_size     s_off_new;
    mrq_pkg::t_size     rd_size;
    mrq_pkg::t_size     rd_count;
    logic               space;
    logic               idx_last;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] p,
                                                 input logic [CNT_W-1:0]  cap);
        logic [SLOT_W:0] inc;
        inc = {1'b0, p} + 1'b1;
        return (inc >= cap) ? '0 : inc[SLOT_W-1:0];
    endfunction

    mrq_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (pay_wr_en),
        .i_wr_addr (pay_wr_addr),
        .i_wr_data (i_cmd.data),
        .i_rd_en   (pay_rd_en),
        .i_rd_addr (pay_rd_addr),
        .o_rd_data (pay_rd_data)
    );

    mrq_ram #(
        .WIDTH (7),
        .DEPTH (SLOTS)
    ) u_sizes (
        .i_clk     (i_clk),
        .i_wr_en   (size_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (size_wr_data),
        .i_rd_en   (size_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (size_rd_data)
    );

    // A new result may start only if it is sure to find room when it lands.
    assign space = ({1'b0, r_qcnt} + {2'b00, r_pend_valid}) < 3'd2;

    // The first item of a send opens it and decides whether it is rejected.
    assign s_off       = r_open ? r_off : '0;
    assign s_rej       = r_open ? r_rej : (r_held >= i_cap);
    assign s_wr        = !s_rej && i_cmd.data_valid && (s_off < i_max);
    assign s_off_new   = s_off + mrq_pkg::t_size'(s_wr);
    assign pay_wr_addr = PAY_AW'({r_tail, s_off[OFF_W-1:0]});
    assign size_wr_data = s_off_new;

    // Stored size, clamped, and the number of bytes to deliver.
    assign rd_size  = (size_rd_data > MAX_BYTES) ? mrq_pkg::t_size'(MAX_BYTES) : size_rd_data;
    assign rd_count = (r_limit < rd_size) ? r_limit : rd_size;

    assign pay_rd_addr = PAY_AW'({r_slot, r_idx[OFF_W-1:0]});
    assign idx_last    = ((r_idx + 1'b1) == r_n);

    // Command execution.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_slot       = r_slot;
        n_held       = r_held;
        n_off        = r_off;
        n_open       = r_open;
        n_rej        = r_rej;
        n_limit      = r_limit;
        n_pop        = r_pop;
        n_size       = r_size;
        n_n          = r_n;
        n_idx        = r_idx;
        n_pend_valid = 1'b0;
        n_pend       = r_pend;
        o_cmd_pop    = 1'b0;
        pay_wr_en    = 1'b0;
        pay_rd_en    = 1'b0;
        size_wr_en   = 1'b0;
        size_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && space) begin
                    o_cmd_pop                  = 1'b1;
                    n_pend                     = '0;
                    n_pend.out_last            = 1'b1;
                    n_pend.queued_count        = mrq_pkg::t_qcnt'(r_held);
                    unique case (i_cmd.kind)
                        mrq_pkg::K_SEND: begin
                            pay_wr_en = s_wr;
                            if (i_cmd.last) begin
                                n_open       = 1'b0;
                                n_rej        = 1'b0;
                                n_off        = '0;
                                n_pend_valid = 1'b1;
                                if (s_rej) begin
                                    n_pend.status = mrq_pkg::ST_FULL;
                                end else begin
                                    size_wr_en          = 1'b1;
                                    n_tail              = f_next(r_tail, i_cap);
                                    n_held              = r_held + 1'b1;
                                    n_pend.status       = mrq_pkg::ST_OK;
                                    n_pend.stored_size  = s_off_new;
                                    n_pend.queued_count = mrq_pkg::t_qcnt'(r_held + 1'b1);
                                end
                            end else begin
                                n_open = 1'b1;
                                n_rej  = s_rej;
                                n_off  = s_off_new;
                            end
                        end
                        mrq_pkg::K_CLEAR: begin
                            n_head              = '0;
                            n_tail              = '0;
                            n_held              = '0;
                            n_off               = '0;
                            n_open              = 1'b0;
                            n_rej               = 1'b0;
                            n_pend_valid        = 1'b1;
                            n_pend.status       = mrq_pkg::ST_OK;
                            n_pend.queued_count = '0;
                        end
                        mrq_pkg::K_READ: begin
                            if (r_held == '0) begin
                                n_pend_valid  = 1'b1;
                                n_pend.status = mrq_pkg::ST_EMPTY;
                            end else begin
                                size_rd_en = 1'b1;
                                n_slot     = r_head;
                                n_limit    = i_cmd.limit;
                                n_pop      = i_cmd.pop;
                                n_state    = S_SIZE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Size of the front message is back from its memory.
            S_SIZE: begin
                n_size  = rd_size;
                n_n     = rd_count;
                n_idx   = '0;
                n_state = S_STREAM;
                if (r_pop) begin
                    n_head = f_next(r_slot, i_cap);
                    n_held = r_held - 1'b1;
                end
            end

            // One byte read per free result slot.
            S_STREAM: begin
                if (space) begin
                    n_pend_valid        = 1'b1;
                    n_pend              = '0;
                    n_pend.status       = mrq_pkg::ST_OK;
                    n_pend.stored_size  = r_size;
                    n_pend.queued_count = mrq_pkg::t_qcnt'(r_held);
                    if (r_n == '0) begin
                        n_pend.out_last = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        pay_rd_en             = 1'b1;
                        n_pend.out_byte_valid = 1'b1;
                        n_pend.out_last       = idx_last;
                        n_idx                 = r_idx + 1'b1;
                        if (idx_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_held       <= '0;
            r_off        <= '0;
            r_open       <= 1'b0;
            r_rej        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_held       <= n_held;
            r_off        <= n_off;
            r_open       <= n_open;
            r_rej        <= n_rej;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Working registers of a read and the pending result carry no reset.
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_limit <= n_limit;
        r_pop   <= n_pop;
        r_size  <= n_size;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_pend  <= n_pend;
    end

    // The pending result picks up its byte from the payload memory.
    always_comb begin
        push_item          = r_pend;
        push_item.out_byte = r_pend.out_byte_valid ? pay_rd_data : '0;
    end

    assign o_out_valid = (r_qcnt != 2'd0);
    assign o_out       = r_q[r_qrp];
    assign q_pop       = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp  <= 1'b0;
            r_qrp  <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (r_pend_valid) begin
                r_qwp <= ~r_qwp;
            end
            if (q_pop) begin
                r_qrp <= ~r_qrp;
            end
            if (r_pend_valid && !q_pop) begin
                r_qcnt <= r_qcnt + 2'd1;
            end else if (!r_pend_valid && q_pop) begin
                r_qcnt <= r_qcnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_valid) begin
            r_q[r_qwp] <= push_item;
        end
    end

endmodule

FILE: hdl/message_ring_queue_unit.sv
// Ring queue of variable-length byte messages held in SLOTS slots of up to
// MAX_BYTES bytes each. A send streams one byte per item and is committed by
// the item with in_last set, which returns one result (ok with the stored
// size, or full when the queue had no free slot at the first byte). Peek and
// pop return min(read_limit, size) byte results, or one result when there is
// nothing to deliver; pop then frees the front slot. Clear empties the queue.
// Items pass through a two-entry command queue into the execution engine, and
// results leave through a two-entry result queue. A peek or pop first looks
// up the size of the front message and then delivers its bytes; each byte
// needs a registered read of the payload memory and a free entry in the
// result queue. Memories need no clearing pass after reset.
module message_ring_queue_unit #(
    parameter int SLOTS     = mrq_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = mrq_pkg::MAX_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mrq_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mrq_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mrq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mrq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int CAP_RST = (SLOTS < 16) ? SLOTS : 16;
    localparam int MAX_RST = (MAX_BYTES < 64) ? MAX_BYTES : 64;

    logic [CNT_W-1:0] r_cap, n_cap;
    mrq_pkg::t_size   r_max, n_max;
    logic             cmd_valid;
    logic             cmd_pop;
    mrq_pkg::t_cmd    cmd;
    logic             cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Registers hold the effective values, clamped into their legal ranges.
    always_comb begin
        if (i_cfg_data[4:0] == 5'd0) begin
            n_cap = CNT_W'(1);
        end else if (i_cfg_data[4:0] > SLOTS) begin
            n_cap = CNT_W'(SLOTS);
        end else begin
            n_cap = CNT_W'(i_cfg_data[4:0]);
        end
        if (i_cfg_data == '0) begin
            n_max = mrq_pkg::t_size'(1);
        end else if (i_cfg_data > MAX_BYTES) begin
            n_max = mrq_pkg::t_size'(MAX_BYTES);
        end else begin
            n_max = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(CAP_RST);
            r_max <= mrq_pkg::t_size'(MAX_RST);
        end else if (cfg_wr) begin
            if (i_cfg_index == mrq_pkg::CFG_SLOT_CAPACITY) begin
                r_cap <= n_cap;
            end else if (i_cfg_index == mrq_pkg::CFG_MAX_MESSAGE_BYTES) begin
                r_max <= n_max;
            end
        end
    end

    mrq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mrq_back #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_max       (r_max),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTH
    // The engine only takes a command that the front end holds.
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty command queue");

    // The input side is held off only while commands are waiting.
    a_stall_has_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> cmd_valid)
        else $error("input stalled with no command waiting");

    // Every result but the last of a run carries a message byte.
    a_inner_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.out_last) |-> o_out.out_byte_valid)
        else $error("non-final result without a byte");

    // A full or empty report is a single result without a byte.
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != mrq_pkg::ST_OK))
            |-> (o_out.out_last && !o_out.out_byte_valid))
        else $error("error status on a byte result");
`endif

endmodule
